### rtl/core/mksort_pkg.sv
// Package for the Morton key bitonic sort unit: sizes, key constants,
// controller state, command/status types and a bit-spread helper. No dependencies.
package mksort_pkg;
  localparam int MaxLeaves = 64;
  localparam int IdxW = 6;
  localparam int CntW = 7;
  localparam int QW = 10;
  localparam logic [31:0] InvalidKey = 32'hFFFF_FFFF;
  localparam int DivSteps = 45;
  localparam int DivCntW = 6;

  typedef enum logic [3:0] {
    ST_LOAD, ST_QRD, ST_QSTART, ST_QDIV, ST_QWRITE, ST_SRD, ST_SWAIT, ST_SCMP,
    ST_ORD, ST_OWAIT, ST_OOUT
  } state_t;

  typedef struct packed {
    logic load;
    logic q_start;
    logic q_write;
    logic s_read;
    logic s_write;
    logic o_read;
    logic o_load;
    logic clear;
    logic [IdxW-1:0] addr_a;
    logic [IdxW-1:0] addr_b;
    logic [CntW-1:0] stage;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_busy;
    logic [CntW-1:0] count;
  } sts_t;

  function automatic logic [29:0] spread10(input logic [QW-1:0] v);
    logic [29:0] r;
    r = '0;
    for (int k = 0; k < QW; k++) r[3*k] = v[k];
    return r;
  endfunction
endpackage

### rtl/core/mksort_ram.sv
// Generic dual-write, dual-read RAM with registered read data.
// No dependencies.
module mksort_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we_a,
  input  logic [$clog2(Depth)-1:0] addr_a,
  input  logic [Width-1:0]         wdata_a,
  input  logic                     we_b,
  input  logic [$clog2(Depth)-1:0] addr_b,
  input  logic [Width-1:0]         wdata_b,
  output logic [Width-1:0]         rdata_a,
  output logic [Width-1:0]         rdata_b
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we_a) mem[addr_a] <= wdata_a;
    if (we_b) mem[addr_b] <= wdata_b;
    rdata_a <= mem[addr_a];
    rdata_b <= mem[addr_b];
  end
endmodule

### rtl/core/mksort_ctrl.sv
// Controller of the Morton key bitonic sort unit: sequences load,
// quantization, sort passes and emission. Depends on mksort_pkg.
module mksort_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_fire,
  input  logic                   in_last,
  input  mksort_pkg::sts_t       sts,
  output mksort_pkg::cmd_t       cmd,
  output logic                   in_rdy
);
  localparam int IW = mksort_pkg::IdxW;
  localparam int CW = mksort_pkg::CntW;
  mksort_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] leaves_r, leaves_nxt, i_r, i_nxt, stage_r, stage_nxt, stride_r, stride_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [CW-1:0] lv, j, cnt_eff;
  logic pair_ok;

  always_comb begin
    cnt_eff = (sts.count < CW'(mksort_pkg::MaxLeaves)) ? sts.count + CW'(1) : sts.count;
    lv = CW'(1);
    for (int k = 0; k < IW; k++) if (lv < cnt_eff) lv = lv << 1;
  end
  assign j = i_r ^ stride_r;
  assign pair_ok = (j > i_r) && (j < leaves_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mksort_pkg::ST_LOAD;
      leaves_r <= '0; i_r <= '0; stage_r <= '0; stride_r <= '0; axis_r <= '0;
    end else begin
      state_r <= state_nxt; leaves_r <= leaves_nxt; i_r <= i_nxt;
      stage_r <= stage_nxt; stride_r <= stride_nxt; axis_r <= axis_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r; leaves_nxt = leaves_r; i_nxt = i_r;
    stage_nxt = stage_r; stride_nxt = stride_r; axis_nxt = axis_r;
    case (state_r)
      mksort_pkg::ST_LOAD: if (in_fire && in_last) begin
        leaves_nxt = lv; i_nxt = '0; axis_nxt = '0;
        state_nxt = mksort_pkg::ST_QRD;
      end
      mksort_pkg::ST_QRD: state_nxt = mksort_pkg::ST_QSTART;
      mksort_pkg::ST_QSTART: state_nxt = mksort_pkg::ST_QDIV;
      mksort_pkg::ST_QDIV: if (sts.div_done) begin
        if (axis_r == 2'd2) state_nxt = mksort_pkg::ST_QWRITE;
        else begin
          axis_nxt = axis_r + 2'd1; state_nxt = mksort_pkg::ST_QSTART;
        end
      end
      mksort_pkg::ST_QWRITE: begin
        axis_nxt = '0;
        if (i_r + CW'(1) == leaves_r) begin
          i_nxt = '0; stage_nxt = CW'(2); stride_nxt = CW'(1);
          state_nxt = (leaves_r == CW'(1)) ? mksort_pkg::ST_ORD : mksort_pkg::ST_SRD;
        end else begin
          i_nxt = i_r + CW'(1); state_nxt = mksort_pkg::ST_QRD;
        end
      end
      mksort_pkg::ST_SRD: state_nxt = pair_ok ? mksort_pkg::ST_SWAIT : mksort_pkg::ST_SCMP;
      mksort_pkg::ST_SWAIT: state_nxt = mksort_pkg::ST_SCMP;
      mksort_pkg::ST_SCMP: begin
        state_nxt = mksort_pkg::ST_SRD;
        if (i_r + CW'(1) != leaves_r) i_nxt = i_r + CW'(1);
        else begin
          i_nxt = '0;
          if (stride_r != CW'(1)) stride_nxt = stride_r >> 1;
          else if (stage_r != leaves_r) begin
            stage_nxt = stage_r << 1; stride_nxt = stage_r;
          end else state_nxt = mksort_pkg::ST_ORD;
        end
      end
      mksort_pkg::ST_ORD: state_nxt = mksort_pkg::ST_OWAIT;
      mksort_pkg::ST_OWAIT: state_nxt = mksort_pkg::ST_OOUT;
      mksort_pkg::ST_OOUT: if (!sts.out_busy) begin
        if (i_r + CW'(1) == leaves_r) state_nxt = mksort_pkg::ST_LOAD;
        else begin
          i_nxt = i_r + CW'(1); state_nxt = mksort_pkg::ST_ORD;
        end
      end
      default: state_nxt = mksort_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.addr_a = i_r[IW-1:0];
    cmd.addr_b = j[IW-1:0];
    cmd.stage = stage_r;
    cmd.axis = axis_r;
    in_rdy = (state_r == mksort_pkg::ST_LOAD);
    case (state_r)
      mksort_pkg::ST_LOAD: cmd.load = in_fire;
      mksort_pkg::ST_QSTART: cmd.q_start = 1'b1;
      mksort_pkg::ST_QWRITE: cmd.q_write = 1'b1;
      mksort_pkg::ST_SRD: cmd.s_read = pair_ok;
      mksort_pkg::ST_SCMP: cmd.s_write = pair_ok;
      mksort_pkg::ST_ORD: cmd.o_read = 1'b1;
      mksort_pkg::ST_OOUT: begin
        cmd.o_load = !sts.out_busy;
        cmd.clear = !sts.out_busy && (i_r + CW'(1) == leaves_r);
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_leaves_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != mksort_pkg::ST_LOAD |-> $onehot(leaves_r)) else $error("leaves not pow2");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != mksort_pkg::ST_LOAD |-> i_r < leaves_r) else $error("index out of range");
  a_rdy_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> in_rdy) else $error("load while busy");
`endif
endmodule

### rtl/core/mksort_dp.sv
// Datapath of the Morton key bitonic sort unit: center and key stores,
// scene box, serial divider, compare-exchange, output register.
// Depends on mksort_pkg and mksort_ram.
module mksort_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mksort_pkg::cmd_t      cmd,
  output mksort_pkg::sts_t      sts,
  input  logic signed [31:0]    lo_x, lo_y, lo_z, hi_x, hi_y, hi_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [39:0]           out_data,
  output logic                  out_user,
  output logic                  out_last
);
  localparam int IW = mksort_pkg::IdxW;
  localparam int CW = mksort_pkg::CntW;
  localparam int QW_T = mksort_pkg::QW;
  logic signed [31:0] smin_r [3], smax_r [3], smin_nxt [3], smax_nxt [3];
  logic [CW-1:0] cnt_r;
  logic signed [31:0] lo [3], hi [3];
  logic [98:0] csum_rd, csum_unused;
  logic [38:0] key_a, key_b, wa, wb;
  logic wea, web;
  logic [IW-1:0] ra, rb;
  logic keep;
  assign lo[0] = lo_x; assign lo[1] = lo_y; assign lo[2] = lo_z;
  assign hi[0] = hi_x; assign hi[1] = hi_y; assign hi[2] = hi_z;
  assign keep = cmd.load && (cnt_r < CW'(mksort_pkg::MaxLeaves));

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      smin_nxt[a] = (lo[a] < smin_r[a]) ? lo[a] : smin_r[a];
      smax_nxt[a] = (hi[a] > smax_r[a]) ? hi[a] : smax_r[a];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      cnt_r <= '0;
      for (int a = 0; a < 3; a++) begin
        smin_r[a] <= 32'sh7FFF_FFFF; smax_r[a] <= 32'sh8000_0000;
      end
    end else if (keep) begin
      cnt_r <= cnt_r + CW'(1);
      smin_r <= smin_nxt; smax_r <= smax_nxt;
    end
  end
  assign sts.count = cnt_r;

  mksort_ram #(.Width(99), .Depth(mksort_pkg::MaxLeaves)) u_csum (
    .clk, .we_a(keep), .addr_a(keep ? cnt_r[IW-1:0] : cmd.addr_a),
    .wdata_a({33'(hi_z) + 33'(lo_z), 33'(hi_y) + 33'(lo_y), 33'(hi_x) + 33'(lo_x)}),
    .we_b(1'b0), .addr_b('0), .wdata_b('0), .rdata_a(csum_rd), .rdata_b(csum_unused));

  // serial restoring divide of 1023*off by 2*ext
  logic signed [32:0] sum_s, mn2;
  logic signed [33:0] ext2;
  logic signed [34:0] off;
  logic [44:0] num_r, num_nxt;
  logic [34:0] den_r, rem_r, rem_nxt;
  logic [35:0] trial;
  logic [mksort_pkg::DivCntW-1:0] dcnt_r;
  logic busy_r, sat0_r, sat1_r;
  logic [QW_T-1:0] q_r [3];
  logic [QW_T-1:0] qres;
  always_comb begin
    case (cmd.axis)
      2'd0: sum_s = $signed(csum_rd[32:0]);
      2'd1: sum_s = $signed(csum_rd[65:33]);
      default: sum_s = $signed(csum_rd[98:66]);
    endcase
  end
  logic signed [31:0] amin, amax;
  assign amin = smin_r[cmd.axis];
  assign amax = smax_r[cmd.axis];
  assign mn2 = 33'(amin) <<< 1;
  assign ext2 = (34'(amax) - 34'(amin)) <<< 1;
  assign off = 35'(sum_s) - 35'(mn2);
  assign trial = {rem_r, num_r[44]} - {1'b0, den_r};
  always_comb begin
    rem_nxt = trial[35] ? {rem_r[33:0], num_r[44]} : trial[34:0];
    num_nxt = {num_r[43:0], ~trial[35]};
  end
  assign qres = sat0_r ? '0 : sat1_r ? '1 : num_nxt[QW_T-1:0];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; dcnt_r <= '0;
    end else if (cmd.q_start) begin
      busy_r <= 1'b1; dcnt_r <= '0;
      sat0_r <= (ext2 <= 0) || (off <= 0);
      sat1_r <= (ext2 > 0) && (off >= 35'(ext2));
      num_r <= 45'(off[33:0]) * 45'd1023;
      den_r <= 35'(ext2[33:0]);
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_nxt; rem_r <= rem_nxt;
      dcnt_r <= dcnt_r + mksort_pkg::DivCntW'(1);
      if (dcnt_r == mksort_pkg::DivCntW'(mksort_pkg::DivSteps - 1)) busy_r <= 1'b0;
    end
  end
  assign sts.div_done = busy_r && (dcnt_r == mksort_pkg::DivCntW'(mksort_pkg::DivSteps - 1));
  always_ff @(posedge clk) begin
    if (sts.div_done) q_r[cmd.axis] <= qres;
  end

  // key store
  logic [31:0] code;
  logic greater, swap;
  assign code = (cmd.addr_a >= cnt_r[IW-1:0] && cnt_r != CW'(mksort_pkg::MaxLeaves)) ?
    mksort_pkg::InvalidKey :
    {2'b00, mksort_pkg::spread10(q_r[0]) | (mksort_pkg::spread10(q_r[1]) << 1) |
     (mksort_pkg::spread10(q_r[2]) << 2)};
  assign greater = (key_a[38:7] > key_b[38:7]) ||
    (key_a[38:7] == key_b[38:7] && key_a[5:0] > key_b[5:0]);
  assign swap = greater == (({1'b0, cmd.addr_a} & cmd.stage) == '0);
  always_comb begin
    wea = cmd.q_write || (cmd.s_write && swap);
    web = cmd.s_write && swap;
    ra = cmd.addr_a; rb = cmd.addr_b;
    wa = cmd.q_write ? {code, 1'b0, cmd.addr_a} : key_b;
    wb = key_a;
  end
  mksort_ram #(.Width(39), .Depth(mksort_pkg::MaxLeaves)) u_keys (
    .clk, .we_a(wea), .addr_a(ra), .wdata_a(wa), .we_b(web), .addr_b(rb),
    .wdata_b(wb), .rdata_a(key_a), .rdata_b(key_b));

  // output register
  logic ov_r;
  logic [39:0] od_r;
  logic ou_r;
  logic ol_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.o_load) ov_r <= 1'b1;
    else if (out_ready) ov_r <= 1'b0;
    if (cmd.o_load) begin
      od_r <= {2'b00, key_a[38:7], key_a[5:0]};
      ou_r <= ({1'b0, key_a[5:0]} >= cnt_r);
      ol_r <= cmd.clear;
    end
  end
  assign sts.out_busy = ov_r && !out_ready;
  assign out_valid = ov_r;
  assign out_data = od_r;
  assign out_user = ou_r;
  assign out_last = ol_r;
endmodule

### rtl/core/morton_key_bitonic_sort_unit.sv
// Morton key bitonic sort unit: boxes in, sorted (index, Morton key) out.
// Bounding boxes stream in one per transaction; the transaction with tlast
// starts quantization (one serial divide per axis for each leaf slot),
// a bitonic network of compare-exchange steps over the key RAM, then one
// result per leaf slot through the output register. Input is held off
// from tlast until the final result is loaded into the output register.
// Depends on mksort_pkg, mksort_ctrl, mksort_dp.
module morton_key_bitonic_sort_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [191:0] in_tdata,  // box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z
  input  logic         in_tlast,  // last_box
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata, // primitive_index, morton_key, pad
  output logic         out_tuser, // is_padding
  output logic         out_tlast  // last_result
);
  mksort_pkg::cmd_t cmd;
  mksort_pkg::sts_t sts;
  logic fire;
  assign fire = in_tvalid && in_tready;

  mksort_ctrl u_ctrl (.clk, .rst_n, .in_fire(fire), .in_last(in_tlast), .sts, .cmd,
    .in_rdy(in_tready));
  mksort_dp u_dp (.clk, .rst_n, .cmd, .sts,
    .lo_x(in_tdata[31:0]), .lo_y(in_tdata[63:32]), .lo_z(in_tdata[95:64]),
    .hi_x(in_tdata[127:96]), .hi_y(in_tdata[159:128]), .hi_z(in_tdata[191:160]),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(out_tdata),
    .out_user(out_tuser), .out_last(out_tlast));
endmodule

### tb/morton_key_bitonic_sort_unit_checker.sv
// Checker for the Morton key bitonic sort unit: watches the box and result
// channels, predicts sorted (index, key) results and compares them.
// Depends on mksort_pkg.
module morton_key_bitonic_sort_unit_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [191:0] in_tdata,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [39:0]  out_tdata,
  input  logic         out_tuser,
  input  logic         out_tlast,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [mksort_pkg::IdxW-1:0] prim_idx;
    logic [31:0]                 key;
    logic                        pad;
    logic                        last;
  } sorted_entry_t;

  sorted_entry_t sorted_q[$];
  longint sum_x[mksort_pkg::MaxLeaves];
  longint sum_y[mksort_pkg::MaxLeaves];
  longint sum_z[mksort_pkg::MaxLeaves];
  longint lo_bound[3];
  longint hi_bound[3];
  int box_cnt;

  function automatic logic [31:0] interleave10(input logic [mksort_pkg::QW-1:0] v);
    logic [31:0] r;
    r = '0;
    for (int k = 0; k < mksort_pkg::QW; k++) r[3*k] = v[k];
    return r;
  endfunction

  function automatic logic [mksort_pkg::QW-1:0] quant_axis(input longint s, input longint mn,
                                                          input longint mx);
    longint ext;
    longint off;
    ext = mx - mn;
    off = s - 2 * mn;
    if (ext <= 0 || off <= 0) return '0;
    if (off >= 2 * ext) return '1;
    return mksort_pkg::QW'((off * 1023) / (2 * ext));
  endfunction

  task automatic clear_scene();
    for (int a = 0; a < 3; a++) begin
      lo_bound[a] = 64'sd2147483647;
      hi_bound[a] = -64'sd2147483648;
    end
    box_cnt = 0;
  endtask

  task automatic finish_run();
    logic [31:0] keys[mksort_pkg::MaxLeaves];
    logic [mksort_pkg::IdxW-1:0] ids[mksort_pkg::MaxLeaves];
    int leaves;
    int j;
    logic [31:0] tk;
    logic [mksort_pkg::IdxW-1:0] ti;
    logic gt;
    sorted_entry_t e;
    leaves = 1;
    while (leaves < box_cnt && leaves < mksort_pkg::MaxLeaves) leaves *= 2;
    for (int i = 0; i < leaves; i++) begin
      keys[i] = mksort_pkg::InvalidKey;
      if (i < box_cnt)
        keys[i] = interleave10(quant_axis(sum_x[i], lo_bound[0], hi_bound[0]))
                | (interleave10(quant_axis(sum_y[i], lo_bound[1], hi_bound[1])) << 1)
                | (interleave10(quant_axis(sum_z[i], lo_bound[2], hi_bound[2])) << 2);
      ids[i] = mksort_pkg::IdxW'(i);
    end
    for (int st = 2; st <= leaves; st *= 2)
      for (int sd = st / 2; sd != 0; sd /= 2)
        for (int i = 0; i < leaves; i++) begin
          j = i ^ sd;
          if (j > i && j < leaves) begin
            gt = keys[i] > keys[j] || (keys[i] == keys[j] && ids[i] > ids[j]);
            if (gt == ((i & st) == 0)) begin
              tk = keys[i]; keys[i] = keys[j]; keys[j] = tk;
              ti = ids[i]; ids[i] = ids[j]; ids[j] = ti;
            end
          end
        end
    for (int i = 0; i < leaves; i++) begin
      e.prim_idx = ids[i];
      e.key = keys[i];
      e.pad = (int'(ids[i]) >= box_cnt);
      e.last = (i + 1 == leaves);
      sorted_q.push_back(e);
    end
    clear_scene();
  endtask

  initial begin
    fail_count = 0;
    clear_scene();
  end

  assign pending = sorted_q.size();

  always @(posedge clk) begin
    sorted_entry_t e;
    longint lo[3];
    longint hi[3];
    if (rst_n && in_tvalid && in_tready) begin
      for (int a = 0; a < 3; a++) begin
        lo[a] = longint'($signed(in_tdata[32*a +: 32]));
        hi[a] = longint'($signed(in_tdata[32*(a+3) +: 32]));
      end
      if (box_cnt < mksort_pkg::MaxLeaves) begin
        sum_x[box_cnt] = lo[0] + hi[0];
        sum_y[box_cnt] = lo[1] + hi[1];
        sum_z[box_cnt] = lo[2] + hi[2];
        for (int a = 0; a < 3; a++) begin
          if (lo[a] < lo_bound[a]) lo_bound[a] = lo[a];
          if (hi[a] > hi_bound[a]) hi_bound[a] = hi[a];
        end
        box_cnt++;
      end
      if (in_tlast) finish_run();
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (sorted_q.size() == 0) begin
        $error("unexpected result transaction: %h last %b", out_tdata, out_tlast);
        fail_count++;
      end else begin
        e = sorted_q.pop_front();
        if (out_tdata[5:0] !== e.prim_idx) begin
          $error("primitive_index: expected %0d, actual %0d", e.prim_idx, out_tdata[5:0]);
          fail_count++;
        end
        if (out_tdata[37:6] !== e.key) begin
          $error("morton_key: expected %h, actual %h", e.key, out_tdata[37:6]);
          fail_count++;
        end
        if (out_tuser !== e.pad) begin
          $error("is_padding: expected %b, actual %b", e.pad, out_tuser);
          fail_count++;
        end
        if (out_tlast !== e.last) begin
          $error("last_result: expected %b, actual %b", e.last, out_tlast);
          fail_count++;
        end
      end
    end
  end
endmodule

### tb/morton_key_bitonic_sort_unit_test.sv
// Testbench top for the Morton key bitonic sort unit: drives box runs with
// random gaps and stalls and gives the verdict from the checker.
// Depends on morton_key_bitonic_sort_unit, its checker and mksort_pkg.
module morton_key_bitonic_sort_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 60000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [191:0] in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [39:0]  out_tdata;
  logic         out_tuser;
  logic         out_tlast;
  int           fail_count;
  int           pending;
  int           idle_cycles = 0;
  bit           no_gaps = 1'b0;
  int           stall_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  morton_key_bitonic_sort_unit DUT (.*);
  morton_key_bitonic_sort_unit_checker u_checker (.*);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_box(input logic [31:0] lx, ly, lz, hx, hy, hz, input logic last);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {hz, hy, hx, lz, ly, lx};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic random_run(input int n);
    logic [31:0] lo[3];
    logic [31:0] hi[3];
    int mode;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(0, 9);
      for (int a = 0; a < 3; a++) begin
        if (mode < 2) begin
          lo[a] = $urandom;
          hi[a] = $urandom;
        end else begin
          lo[a] = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
          hi[a] = lo[a] + $urandom_range(0, 32'h0004_0000);
        end
      end
      send_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], i == n - 1);
    end
  endtask

  initial begin
    int n;
    int k;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    send_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
             32'hFFFF_FFFF, 1'b1);
    send_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 1'b0);
    send_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_box(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0,
             32'h7FFF_FFFF, 1'b1);
    repeat (3) send_box(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                        32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
    send_box(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
             32'h0001_0000, 32'h0001_0000, 1'b1);
    send_box(32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 32'h0001_0000,
             32'h0001_0000, 32'h0001_0000, 1'b0);
    send_box(32'h0003_0000, 32'h0006_0000, 32'h0002_0000, 32'h0002_0000,
             32'h0001_0000, 32'h0001_0000, 1'b1);
    send_box(32'hFFFF_0000, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000,
             32'h0003_0000, 1'b0);
    send_box(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    send_box(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000,
             32'h0002_0000, 32'h0003_0000, 1'b1);
    no_gaps = 1'b1;
    random_run(66);
    no_gaps = 1'b0;
    random_run(64);
    n = 0;
    while (n < 60) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      k = $urandom_range(1, 12);
      random_run(k);
      n += k;
    end
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
